// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/mor_pkg.sv =====
// ----------------------------------------------------------------------------
// mor_pkg
// Types and fixed constants of the maximal ones rectangle block.
// ----------------------------------------------------------------------------
`default_nettype none

package mor_pkg;

  localparam int unsigned AREA_W = 17;
  localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;

  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] COLUMN_COUNT_RST = 7'd64;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  // Register word indexes
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b0;

  // Control of the shared area unit
  typedef struct packed {
    logic mul_en;   // register height times span
    logic acc_en;   // fold the registered product into the best area
    logic clr;      // drop the best area
  } area_ctl_t;

endpackage

`default_nettype wire

// ===== design/mor_ram.sv =====
// ----------------------------------------------------------------------------
// mor_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mor_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/mor_area.sv =====
// ----------------------------------------------------------------------------
// mor_area
// Shared area unit: one registered multiply, saturation and running maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module mor_area #(
  parameter int unsigned HEIGHT_W = 11,
  parameter int unsigned SPAN_W   = 7
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mor_pkg::area_ctl_t            ctl_i,
  input  wire logic [HEIGHT_W-1:0]           height_i,
  input  wire logic [SPAN_W-1:0]             span_i,
  output logic      [mor_pkg::AREA_W-1:0]    best_o
);

  import mor_pkg::*;

  localparam int unsigned PROD_W = HEIGHT_W + SPAN_W;
  localparam int unsigned EXT_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  logic [AREA_W-1:0] best_q;
  logic [AREA_W-1:0] best_d;
  logic [EXT_W-1:0]  prod_ext;
  logic [AREA_W-1:0] area_sat;

  assign prod_d   = PROD_W'(height_i) * PROD_W'(span_i);
  assign prod_ext = EXT_W'(prod_q);
  assign area_sat = (prod_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : AREA_W'(prod_ext);

  always_comb begin
    best_d = best_q;
    if (ctl_i.clr) begin
      best_d = '0;
    end else if (ctl_i.acc_en && (area_sat > best_q)) begin
      best_d = area_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

// ===== design/maximal_ones_rectangle.sv =====
// ----------------------------------------------------------------------------
// maximal_ones_rectangle
// Largest all-ones rectangle of a binary matrix streamed one cell per item.
// ----------------------------------------------------------------------------
// The matrix arrives in row-major order, one cell bit per item, with the row
// length set by the column_count register (byte address 0; zero counts as
// one column, values above MAX_COLS count as MAX_COLS). Per column the block
// keeps the height of the run of ones ending at the current row, saturating
// at MAX_ROWS; at each row end it runs the monotonic-stack histogram pass and
// keeps the best area, which it delivers as one item on the cell marked
// matrix_end (a row is closed early there) before clearing heights and best
// area for the next matrix. A cell that does not end a row is accepted and
// then takes the height read-modify-write through the height RAM. A cell
// that ends a row also gets a stack pass, and a finish step on the matrix
// end: the stack pass visits each column for a push (fetch, load, compare)
// and for a pop (compare, multiply, fold into the maximum), all through one
// height RAM port, one stack RAM port and one shared multiplier. in_stall_o
// is low only between items. The result sits in an output register, so the
// next matrix streams in while it waits to be taken; the block holds only
// when a second result is ready before the first one left. Heights need no
// clearing pass: a valid bit per column makes an unwritten column read zero.
// Write column_count only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_ones_rectangle #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mor_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [mor_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [mor_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // Cell input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cell_bit_i,
  input  wire logic                              matrix_end_i,
  // Result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [mor_pkg::AREA_W-1:0]        max_area_o
);

  import mor_pkg::*;

  // Column index, column count / stack depth, and height widths
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned IW = $clog2(MAX_COLS + 1);
  localparam int unsigned HW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NW = (IW > CNT_W) ? IW : CNT_W;
  localparam int unsigned SW = CW + HW;   // stack entry: column index and height

  typedef enum logic [2:0] {
    ST_IDLE,      // wait for a cell; height read of the current column in flight
    ST_UPDATE,    // write back the new height, decide on row end
    ST_FETCH,     // present column i to the height RAM
    ST_LOAD,      // capture the height of column i (zero for the sentinel)
    ST_COMPARE,   // pop while the stack top is not lower, else push or end the pass
    ST_POP,       // drop the top, multiply its height by its span
    ST_SCORE,     // fold the product into the best area
    ST_FINISH     // hand the best area to the output register, clear
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic              cell_q, cell_d;
  logic              last_q, last_d;
  logic [MAX_COLS-1:0] hvalid_q, hvalid_d;
  logic [IW-1:0]     i_q, i_d;
  logic [IW-1:0]     depth_q, depth_d;
  logic [HW-1:0]     top_h_q, top_h_d;
  logic [HW-1:0]     cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  logic [AREA_W-1:0] max_area_q, max_area_d;

  logic [NW-1:0]     cnt_ext;
  logic [IW-1:0]     n_cols;
  logic              row_end;
  logic              cfg_wr;
  logic              cfg_sel;

  logic              h_we;
  logic [CW-1:0]     h_raddr;
  logic [HW-1:0]     h_wdata;
  logic [HW-1:0]     h_rdata;
  logic [HW-1:0]     h_old;

  logic              s_we;
  logic [CW-1:0]     s_raddr;
  logic [SW-1:0]     s_wdata;
  logic [SW-1:0]     s_rdata;
  logic [CW-1:0]     below_idx;
  logic [HW-1:0]     below_h;

  logic [IW-1:0]     span;
  area_ctl_t         area_ctl;
  logic [AREA_W-1:0] best_area;

  // Configuration decode; low address bits are ignored within the word
  assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_COLUMN_COUNT);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? APB_DATA_W'(count_q) : '0;

  // Effective column count: zero means one, clamp at MAX_COLS
  assign cnt_ext = NW'(count_q);
  always_comb begin
    if (cnt_ext == '0) begin
      n_cols = IW'(1);
    end else if (cnt_ext > NW'(MAX_COLS)) begin
      n_cols = IW'(MAX_COLS);
    end else begin
      n_cols = IW'(cnt_ext);
    end
  end

  // A lowered count closes the row at the current cell
  assign row_end = last_q || ((IW'(pos_q) + IW'(1)) >= n_cols);

  // Height read-modify-write for the current column
  assign h_raddr = (state_q == ST_IDLE) ? pos_q : CW'(i_q);
  assign h_old   = hvalid_q[pos_q] ? h_rdata : '0;
  always_comb begin
    if (!cell_q) begin
      h_wdata = '0;
    end else if (h_old < HW'(MAX_ROWS)) begin
      h_wdata = h_old + HW'(1);
    end else begin
      h_wdata = h_old;
    end
  end

  // Stack: RAM holds every entry, top height also cached in a register
  assign s_raddr   = CW'(depth_q - IW'(2));
  assign s_wdata   = {CW'(i_q), cur_q};
  assign below_idx = s_rdata[SW-1:HW];
  assign below_h   = s_rdata[HW-1:0];

  // Span of the popped bar: to column zero when the stack empties
  assign span = (depth_q == IW'(1)) ? i_q : (i_q - IW'(below_idx) - IW'(1));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    cell_d      = cell_q;
    last_d      = last_q;
    hvalid_d    = hvalid_q;
    i_d         = i_q;
    depth_d     = depth_q;
    top_h_d     = top_h_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    max_area_d  = max_area_q;
    h_we        = 1'b0;
    s_we        = 1'b0;
    area_ctl    = '0;

    if (cfg_wr) begin
      count_d = pwdata[CNT_W-1:0];
    end

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cell_d  = cell_bit_i;
          last_d  = matrix_end_i;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        h_we            = 1'b1;
        hvalid_d[pos_q] = 1'b1;
        if (row_end) begin
          pos_d   = '0;
          i_d     = '0;
          depth_d = '0;
          state_d = ST_FETCH;
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Past the last column acts as a zero-height bar that drains the stack
        if ((i_q < n_cols) && hvalid_q[CW'(i_q)]) begin
          cur_d = h_rdata;
        end else begin
          cur_d = '0;
        end
        state_d = ST_COMPARE;
      end
      ST_COMPARE: begin
        if ((depth_q != '0) && (top_h_q >= cur_q)) begin
          state_d = ST_POP;
        end else if (i_q < n_cols) begin
          s_we      = 1'b1;
          top_h_d   = cur_q;
          depth_d   = depth_q + IW'(1);
          i_d       = i_q + IW'(1);
          state_d   = ST_FETCH;
        end else if (last_q) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_POP: begin
        area_ctl.mul_en = 1'b1;
        top_h_d         = below_h;
        depth_d         = depth_q - IW'(1);
        state_d         = ST_SCORE;
      end
      ST_SCORE: begin
        area_ctl.acc_en = 1'b1;
        state_d         = ST_COMPARE;
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          max_area_d   = best_area;
          area_ctl.clr = 1'b1;
          hvalid_d     = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= COLUMN_COUNT_RST;
      pos_q       <= '0;
      cell_q      <= 1'b0;
      last_q      <= 1'b0;
      hvalid_q    <= '0;
      i_q         <= '0;
      depth_q     <= '0;
      top_h_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      max_area_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      cell_q      <= cell_d;
      last_q      <= last_d;
      hvalid_q    <= hvalid_d;
      i_q         <= i_d;
      depth_q     <= depth_d;
      top_h_q     <= top_h_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      max_area_q  <= max_area_d;
    end
  end

  mor_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_COLS)
  ) u_heights (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (pos_q),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  mor_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (CW'(depth_q)),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  mor_area #(
    .HEIGHT_W (HW),
    .SPAN_W   (IW)
  ) u_area (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (area_ctl),
    .height_i (top_h_q),
    .span_i   (span),
    .best_o   (best_area)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign max_area_o  = max_area_q;

endmodule

`default_nettype wire

// ===== design/mor_checker.sv =====
// ----------------------------------------------------------------------------
// mor_checker
// Port-level checks of the maximal ones rectangle block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mor_checker #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 1024
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           matrix_end_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [mor_pkg::AREA_W-1:0]     max_area_o
);

  import mor_pkg::*;

  localparam longint unsigned AREA_CAP   = longint'(MAX_COLS) * longint'(MAX_ROWS);
  localparam longint unsigned AREA_BOUND =
    (AREA_CAP > longint'(AREA_MAX)) ? longint'(AREA_MAX) : AREA_CAP;

  logic held_q;      // result was stalled at the last edge
  logic pending_q;   // a matrix end was taken and its result not shown yet
  logic new_result;

  // A result is new when the slot was empty or its item left at the last edge
  assign new_result = out_valid_o && !held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      held_q <= out_valid_o && out_stall_i;
      if (in_valid_i && !in_stall_o && matrix_end_i) begin
        pending_q <= 1'b1;
      end else if (new_result) begin
        pending_q <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_result_needs_end, clk_i, rst_ni, new_result, pending_q, "result without matrix end")
  `ASSERT_IMPLIES(a_area_bound, clk_i, rst_ni, out_valid_o, max_area_o <= AREA_W'(AREA_BOUND), "area above bound")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(max_area_o), "stalled result changed")

endmodule

bind maximal_ones_rectangle mor_checker #(
  .MAX_COLS (MAX_COLS),
  .MAX_ROWS (MAX_ROWS)
) u_mor_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .matrix_end_i (matrix_end_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .max_area_o   (max_area_o)
);

`default_nettype wire
